/* hdl/assert_macros.svh */
// Assertion macros shared by the simplex noise RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SNF_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("simplex noise assertion failed");

// Next-cycle implication, disabled during reset.
`define SNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("simplex noise assertion failed");

`endif

/* hdl/snf_pkg.sv */
// Package for the simplex noise pipeline: widths, constants, tables and types.
// Depends on nothing; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package snf_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned R_W     = 11;
  localparam int unsigned CONTRIB_W = 27;

  // Reciprocals for exact truncating division of magnitudes by 3 and by 6.
  localparam logic [26:0] RECIP3 = 27'd89478486;
  localparam logic [29:0] RECIP6 = 30'd715827883;

  localparam logic [15:0] WEIGHT_BASE = 16'd39322;
  localparam logic [7:0]  BIAS_C0 = 8'd0;
  localparam logic [7:0]  BIAS_C1 = 8'd43;
  localparam logic [7:0]  BIAS_C2 = 8'd85;
  localparam logic [7:0]  BIAS_C3 = 8'd128;
  localparam logic [2:0]  OFF_NONE = 3'b000;
  localparam logic [2:0]  OFF_ALL  = 3'b111;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Gradient table entry: {negate first, first axis, negate second, second axis}.
  localparam logic [5:0] GRAD_SEL [16] = '{
    {1'b0, AXIS_X, 1'b0, AXIS_Y}, {1'b0, AXIS_X, 1'b1, AXIS_Y},
    {1'b1, AXIS_X, 1'b0, AXIS_Y}, {1'b1, AXIS_X, 1'b1, AXIS_Y},
    {1'b0, AXIS_X, 1'b0, AXIS_Z}, {1'b0, AXIS_X, 1'b1, AXIS_Z},
    {1'b1, AXIS_X, 1'b0, AXIS_Z}, {1'b1, AXIS_X, 1'b1, AXIS_Z},
    {1'b0, AXIS_Y, 1'b0, AXIS_Z}, {1'b0, AXIS_Y, 1'b1, AXIS_Z},
    {1'b1, AXIS_Y, 1'b0, AXIS_Z}, {1'b1, AXIS_Y, 1'b1, AXIS_Z},
    {1'b0, AXIS_X, 1'b0, AXIS_Y}, {1'b1, AXIS_X, 1'b0, AXIS_Y},
    {1'b0, AXIS_Y, 1'b0, AXIS_Z}, {1'b0, AXIS_Y, 1'b1, AXIS_Z}
  };

  localparam logic [7:0] PERM [256] = '{
    8'd99, 8'd147, 8'd142, 8'd89, 8'd96, 8'd166, 8'd18, 8'd157,
    8'd66, 8'd229, 8'd25, 8'd161, 8'd139, 8'd10, 8'd236, 8'd101,
    8'd195, 8'd232, 8'd32, 8'd128, 8'd165, 8'd255, 8'd8, 8'd126,
    8'd239, 8'd163, 8'd112, 8'd180, 8'd234, 8'd85, 8'd191, 8'd189,
    8'd214, 8'd7, 8'd122, 8'd48, 8'd111, 8'd202, 8'd199, 8'd196,
    8'd47, 8'd219, 8'd9, 8'd84, 8'd127, 8'd21, 8'd50, 8'd17,
    8'd186, 8'd97, 8'd225, 8'd123, 8'd194, 8'd170, 8'd223, 8'd107,
    8'd38, 8'd28, 8'd230, 8'd154, 8'd177, 8'd45, 8'd27, 8'd51,
    8'd151, 8'd164, 8'd133, 8'd61, 8'd222, 8'd173, 8'd149, 8'd39,
    8'd156, 8'd42, 8'd200, 8'd49, 8'd141, 8'd224, 8'd117, 8'd108,
    8'd159, 8'd118, 8'd1, 8'd150, 8'd71, 8'd60, 8'd208, 8'd35,
    8'd78, 8'd52, 8'd210, 8'd217, 8'd197, 8'd0, 8'd231, 8'd94,
    8'd31, 8'd148, 8'd30, 8'd119, 8'd82, 8'd175, 8'd201, 8'd6,
    8'd138, 8'd36, 8'd20, 8'd220, 8'd22, 8'd242, 8'd233, 8'd16,
    8'd247, 8'd250, 8'd168, 8'd131, 8'd244, 8'd241, 8'd14, 8'd162,
    8'd121, 8'd87, 8'd221, 8'd57, 8'd206, 8'd120, 8'd238, 8'd92,
    8'd41, 8'd93, 8'd77, 8'd26, 8'd73, 8'd100, 8'd169, 8'd145,
    8'd80, 8'd63, 8'd205, 8'd3, 8'd227, 8'd179, 8'd209, 8'd103,
    8'd67, 8'd37, 8'd56, 8'd167, 8'd104, 8'd55, 8'd116, 8'd198,
    8'd98, 8'd171, 8'd15, 8'd146, 8'd34, 8'd207, 8'd213, 8'd129,
    8'd245, 8'd155, 8'd23, 8'd132, 8'd228, 8'd113, 8'd44, 8'd4,
    8'd19, 8'd115, 8'd72, 8'd90, 8'd102, 8'd187, 8'd134, 8'd105,
    8'd181, 8'd64, 8'd124, 8'd91, 8'd212, 8'd65, 8'd160, 8'd243,
    8'd183, 8'd204, 8'd211, 8'd59, 8'd193, 8'd53, 8'd24, 8'd136,
    8'd83, 8'd158, 8'd29, 8'd33, 8'd74, 8'd62, 8'd252, 8'd144,
    8'd185, 8'd86, 8'd79, 8'd248, 8'd226, 8'd216, 8'd237, 8'd95,
    8'd140, 8'd215, 8'd12, 8'd184, 8'd188, 8'd249, 8'd40, 8'd240,
    8'd172, 8'd43, 8'd253, 8'd246, 8'd153, 8'd75, 8'd5, 8'd46,
    8'd13, 8'd251, 8'd70, 8'd109, 8'd190, 8'd114, 8'd106, 8'd192,
    8'd58, 8'd182, 8'd135, 8'd54, 8'd152, 8'd69, 8'd178, 8'd203,
    8'd130, 8'd81, 8'd76, 8'd174, 8'd254, 8'd235, 8'd137, 8'd143,
    8'd218, 8'd2, 8'd176, 8'd68, 8'd125, 8'd11, 8'd110, 8'd88
  };

  // Cell indices (low 8 bits), offsets from the origin corner, and corner orders.
  typedef struct packed {
    logic [7:0]            ix;
    logic [7:0]            iy;
    logic [7:0]            iz;
    logic signed [R_W-1:0] rx;
    logic signed [R_W-1:0] ry;
    logic signed [R_W-1:0] rz;
    logic [2:0]            off_a;
    logic [2:0]            off_b;
  } snf_point_t;

endpackage

`default_nettype wire

/* hdl/snf_skew.sv */
// Skew, cell floor, unskew and corner ordering: seven register stages.
// Depends on snf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snf_skew (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [snf_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [snf_pkg::COORD_W-1:0]   coord_y_i,
  input  logic signed [snf_pkg::COORD_W-1:0]   coord_z_i,
  output snf_pkg::snf_point_t                  pt_o
);

  // Stage 1: coordinate sum and its magnitude.
  logic signed [26:0] sum_d;
  logic signed [26:0] sum_neg;
  logic signed [23:0] c1_q [3];
  logic               sneg1_q;
  logic [25:0]        sabs1_q;

  assign sum_d   = 27'(coord_x_i) + 27'(coord_y_i) + 27'(coord_z_i) + 27'sd1;
  assign sum_neg = -sum_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q[0] <= coord_x_i;
      c1_q[1] <= coord_y_i;
      c1_q[2] <= coord_z_i;
      sneg1_q <= sum_d[26];
      sabs1_q <= sum_d[26] ? sum_neg[25:0] : sum_d[25:0];
    end
  end

  // Stage 2: magnitude times the reciprocal of 3.
  logic signed [23:0] c2_q [3];
  logic               sneg2_q;
  logic [52:0]        prod3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q    <= c1_q;
      sneg2_q <= sneg1_q;
      prod3_q <= 53'(sabs1_q) * 53'(snf_pkg::RECIP3);
    end
  end

  // Stage 3: signed skew and skewed coordinates.
  logic signed [25:0] skew_d;
  logic signed [25:0] skew3_q;
  logic signed [26:0] xs3_q [3];

  always_comb begin
    skew_d = $signed({1'b0, prod3_q[52:28]});
    if (sneg2_q) begin
      skew_d = -skew_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      skew3_q <= skew_d;
      for (int a = 0; a < 3; a++) begin
        xs3_q[a] <= 27'(c2_q[a]) + 27'(skew_d);
      end
    end
  end

  // Stage 4: sum of the floored cell corner plus rounding term.
  logic signed [28:0] tsum_d;
  logic signed [28:0] tsum_neg;
  logic signed [25:0] skew4_q;
  logic [7:0]         frac4_q [3];
  logic [7:0]         idx4_q [3];
  logic               tneg4_q;
  logic [27:0]        tabs4_q;

  assign tsum_d = 29'($signed({xs3_q[0][26:8], 8'd0}))
                + 29'($signed({xs3_q[1][26:8], 8'd0}))
                + 29'($signed({xs3_q[2][26:8], 8'd0})) + 29'sd3;
  assign tsum_neg = -tsum_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      skew4_q <= skew3_q;
      for (int a = 0; a < 3; a++) begin
        frac4_q[a] <= xs3_q[a][7:0];
        idx4_q[a]  <= xs3_q[a][15:8];
      end
      tneg4_q <= tsum_d[28];
      tabs4_q <= tsum_d[28] ? tsum_neg[27:0] : tsum_d[27:0];
    end
  end

  // Stage 5: magnitude times the reciprocal of 6.
  logic signed [25:0] skew5_q;
  logic [7:0]         frac5_q [3];
  logic [7:0]         idx5_q [3];
  logic               tneg5_q;
  logic [57:0]        prod6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      skew5_q <= skew4_q;
      frac5_q <= frac4_q;
      idx5_q  <= idx4_q;
      tneg5_q <= tneg4_q;
      prod6_q <= 58'(tabs4_q) * 58'(snf_pkg::RECIP6);
    end
  end

  // Stage 6: unskew and offsets from the origin corner.
  logic signed [27:0]             unskew_d;
  logic signed [27:0]             rfull_d [3];
  logic signed [snf_pkg::R_W-1:0] r6_q [3];
  logic [7:0]                     idx6_q [3];

  always_comb begin
    unskew_d = $signed({2'b00, prod6_q[57:32]});
    if (tneg5_q) begin
      unskew_d = -unskew_d;
    end
    for (int a = 0; a < 3; a++) begin
      rfull_d[a] = $signed({20'd0, frac5_q[a]}) - 28'(skew5_q) + unskew_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx6_q <= idx5_q;
      for (int a = 0; a < 3; a++) begin
        r6_q[a] <= rfull_d[a][snf_pkg::R_W-1:0];
      end
    end
  end

  // Stage 7: ordering of the offsets picks the middle two corners.
  logic ax, ay, bx, by;
  snf_pkg::snf_point_t pt_q;

  always_comb begin
    if (r6_q[0] >= r6_q[1]) begin
      bx = 1'b1;
      ay = 1'b0;
      if (r6_q[1] >= r6_q[2]) begin
        ax = 1'b1;
        by = 1'b1;
      end else if (r6_q[0] >= r6_q[2]) begin
        ax = 1'b1;
        by = 1'b0;
      end else begin
        ax = 1'b0;
        by = 1'b0;
      end
    end else begin
      ax = 1'b0;
      by = 1'b1;
      if (r6_q[0] >= r6_q[2]) begin
        ay = 1'b1;
        bx = 1'b1;
      end else if (r6_q[1] >= r6_q[2]) begin
        ay = 1'b1;
        bx = 1'b0;
      end else begin
        ay = 1'b0;
        bx = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q.ix    <= idx6_q[0];
      pt_q.iy    <= idx6_q[1];
      pt_q.iz    <= idx6_q[2];
      pt_q.rx    <= r6_q[0];
      pt_q.ry    <= r6_q[1];
      pt_q.rz    <= r6_q[2];
      pt_q.off_a <= {~(ax | ay), ay, ax};
      pt_q.off_b <= {~(bx & by), by, bx};
    end
  end

  assign pt_o = pt_q;

endmodule

`default_nettype wire

/* hdl/snf_corner.sv */
// One simplex corner: permutation hash, falloff weight and gradient product.
// Six register stages. Depends on snf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snf_corner (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  snf_pkg::snf_point_t                    pt_i,
  input  logic [2:0]                             off_i,
  input  logic [7:0]                             bias_i,
  output logic signed [snf_pkg::CONTRIB_W-1:0]   contrib_o
);

  localparam int unsigned RW = snf_pkg::R_W;

  logic [7:0]          idx_d [3];
  logic signed [RW-1:0] rin_d [3];
  logic [7:0]          grid_d [3];
  logic signed [11:0]  rc_d [3];

  assign idx_d = '{pt_i.ix, pt_i.iy, pt_i.iz};
  assign rin_d = '{pt_i.rx, pt_i.ry, pt_i.rz};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      grid_d[a] = idx_d[a] + {7'd0, off_i[a]};
      rc_d[a]   = 12'(rin_d[a]) - (off_i[a] ? 12'sd256 : 12'sd0)
                + $signed({4'd0, bias_i});
    end
  end

  // Stage 1: first hash level.
  logic [7:0]           h1_q, gy1_q, gz1_q;
  logic signed [RW-1:0] r1_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q  <= snf_pkg::PERM[grid_d[0]];
      gy1_q <= grid_d[1];
      gz1_q <= grid_d[2];
      for (int a = 0; a < 3; a++) begin
        r1_q[a] <= rc_d[a][RW-1:0];
      end
    end
  end

  // Stage 2: second hash level and squared offsets.
  logic [7:0]           h2_q, gz2_q;
  logic signed [RW-1:0] r2_q [3];
  logic [16:0]          sq2_q [3];
  logic signed [21:0]   sqf_d [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sqf_d[a] = 22'(r1_q[a]) * 22'(r1_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q  <= snf_pkg::PERM[8'(gy1_q + h1_q)];
      gz2_q <= gz1_q;
      r2_q  <= r1_q;
      for (int a = 0; a < 3; a++) begin
        sq2_q[a] <= sqf_d[a][16:0];
      end
    end
  end

  // Stage 3: last hash level and weight; a non-positive weight becomes zero.
  logic [3:0]           h3_q;
  logic signed [RW-1:0] r3_q [3];
  logic [15:0]          w3_q;
  logic signed [19:0]   w_d;
  logic [7:0]           h3_d;

  assign w_d  = $signed({4'd0, snf_pkg::WEIGHT_BASE}) - $signed({3'd0, sq2_q[0]})
              - $signed({3'd0, sq2_q[1]}) - $signed({3'd0, sq2_q[2]});
  assign h3_d = snf_pkg::PERM[8'(gz2_q + h2_q)];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h3_q <= h3_d[3:0];
      r3_q <= r2_q;
      w3_q <= (w_d > 20'sd0) ? w_d[15:0] : 16'd0;
    end
  end

  // Stage 4: first squaring of the weight and gradient sum.
  logic [31:0]        wsq_d;
  logic [5:0]         gsel_d;
  logic signed [11:0] t1_d, t2_d;
  logic [14:0]        w2_q;
  logic signed [11:0] g4_q;

  function automatic logic signed [11:0] pick(input logic [1:0] axis,
                                              input logic signed [RW-1:0] rx,
                                              input logic signed [RW-1:0] ry,
                                              input logic signed [RW-1:0] rz);
    logic signed [11:0] v;
    unique case (axis)
      snf_pkg::AXIS_X: v = 12'(rx);
      snf_pkg::AXIS_Y: v = 12'(ry);
      snf_pkg::AXIS_Z: v = 12'(rz);
      default:         v = 12'sd0;
    endcase
    return v;
  endfunction

  always_comb begin
    wsq_d  = 32'(w3_q) * 32'(w3_q) + 32'd32768;
    gsel_d = snf_pkg::GRAD_SEL[h3_q];
    t1_d   = pick(gsel_d[4:3], r3_q[0], r3_q[1], r3_q[2]);
    t2_d   = pick(gsel_d[1:0], r3_q[0], r3_q[1], r3_q[2]);
    if (gsel_d[5]) begin
      t1_d = -t1_d;
    end
    if (gsel_d[2]) begin
      t2_d = -t2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w2_q <= wsq_d[30:16];
      g4_q <= t1_d + t2_d;
    end
  end

  // Stage 5: second squaring.
  logic [29:0]        w4sq_d;
  logic [13:0]        w4_q;
  logic signed [11:0] g5_q;

  assign w4sq_d = 30'(w2_q) * 30'(w2_q) + 30'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w4_q <= w4sq_d[29:16];
      g5_q <= g4_q;
    end
  end

  // Stage 6: weighted gradient.
  logic signed [snf_pkg::CONTRIB_W-1:0] contrib_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      contrib_q <= 27'($signed({1'b0, w4_q})) * 27'(g5_q);
    end
  end

  assign contrib_o = contrib_q;

endmodule

`default_nettype wire

/* hdl/simplex_noise_3d_fixed.sv */
// Fixed-point 3D simplex noise, one byte per point, pipelined.
// Throughput is one request per cycle while the output is not stalled, set by
// the single-issue pipeline of 16 stages.
// The whole pipeline holds while a result waits on a stalled output.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
// Depends on snf_pkg, snf_skew, snf_corner and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module simplex_noise_3d_fixed (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [snf_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [snf_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [snf_pkg::COORD_W-1:0] coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         noise_value_o
);

  // Stage map: seven stages of skew and ordering, six per corner, then two
  // stages of summation and the output register.
  localparam int unsigned DEPTH = 16;

  logic [DEPTH-1:0] vld_q;
  logic             en;

  // Every stage advances together unless a finished result is held at the
  // output. Bubbles keep their slot, which is harmless at one request a cycle.
  assign en = !(vld_q[DEPTH-1] && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  snf_pkg::snf_point_t pt;

  snf_skew u_skew (
    .clk_i     (clk_i),
    .en_i      (en),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .pt_o      (pt)
  );

  // The four corners: origin, the two picked by ordering, and the far corner.
  logic signed [snf_pkg::CONTRIB_W-1:0] contrib [4];
  logic [2:0] corner_off [4];
  logic [7:0] corner_bias [4];

  assign corner_off  = '{snf_pkg::OFF_NONE, pt.off_a, pt.off_b, snf_pkg::OFF_ALL};
  assign corner_bias = '{snf_pkg::BIAS_C0, snf_pkg::BIAS_C1,
                         snf_pkg::BIAS_C2, snf_pkg::BIAS_C3};

  for (genvar c = 0; c < 4; c++) begin : g_corner
    snf_corner u_corner (
      .clk_i     (clk_i),
      .en_i      (en),
      .pt_i      (pt),
      .off_i     (corner_off[c]),
      .bias_i    (corner_bias[c]),
      .contrib_o (contrib[c])
    );
  end

  // Summation in two stages.
  logic signed [27:0] s01_q, s23_q;
  logic signed [28:0] tot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s01_q <= 28'(contrib[0]) + 28'(contrib[1]);
      s23_q <= 28'(contrib[2]) + 28'(contrib[3]);
      tot_q <= 29'(s01_q) + 29'(s23_q);
    end
  end

  // Round to nearest by adding half and flooring the shift, center at 128,
  // then clamp to the byte range.
  logic signed [28:0] rnd_d;
  logic signed [17:0] val_d;
  logic [7:0]         noise_d;
  logic [7:0]         noise_q;

  always_comb begin
    rnd_d = tot_q + 29'sd2048;
    val_d = 18'($signed(rnd_d[28:12])) + 18'sd128;
    if (val_d < 18'sd0) begin
      noise_d = 8'd0;
    end else if (val_d > 18'sd255) begin
      noise_d = 8'd255;
    end else begin
      noise_d = val_d[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= noise_d;
    end
  end

  assign in_stall_o    = !en;
  assign out_valid_o   = vld_q[DEPTH-1];
  assign noise_value_o = noise_q;

  // A request in the next-to-last stage reaches the output when not held.
  `SNF_ASSERT_NEXT(a_advance, clk_i, rst_ni, (vld_q[DEPTH-2] && !in_stall_o), out_valid_o)
  // While held, no stage gains or loses a request.
  `SNF_ASSERT_NEXT(a_freeze, clk_i, rst_ni, in_stall_o, $stable(vld_q))
  // The input is only held back because of a pending result.
  `SNF_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

`default_nettype wire
